// ===== rtl/central_binomial_mod_prime_assert.svh =====
// assertion macros shared by the checker of the central binomial block
// each macro expects signals named clk and rst in the scope where it is used
`ifndef CENTRAL_BINOMIAL_MOD_PRIME_ASSERT_SVH
`define CENTRAL_BINOMIAL_MOD_PRIME_ASSERT_SVH

// same-cycle implication, off while in reset
`define CBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbm check failed");

// next-cycle implication, off while in reset
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbm check failed");

// what must hold in the cycle after a reset edge
`define CBM_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("cbm check failed");

`endif

// ===== rtl/cbm_pkg.sv =====
// shared types, constants and microcode for the central binomial block
// no dependencies
package cbm_pkg;

  // field widths and the modulus
  localparam int unsigned N_W        = 13;
  localparam int unsigned VAL_W      = 30;
  localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [VAL_W-1:0] FERMAT_EXP = PRIME - 30'd2;

  // barrett reduction constants
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned MU_W   = 31;
  localparam int unsigned RED_W  = 32;
  localparam logic [63:0] MU_WIDE = (64'd1 << PROD_W) / {34'd0, PRIME};
  localparam logic [MU_W-1:0] MU  = MU_WIDE[MU_W-1:0];

  // multiplier result destinations
  typedef enum logic [1:0] {
    DST_F, DST_ACC, DST_BASE, DST_R
  } dst_t;

  typedef struct packed {
    logic             valid;
    dst_t             dest;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             valid;
    logic             busy;
    dst_t             dest;
    logic [VAL_W-1:0] value;
  } mm_rsp_t;

  // control word fields
  typedef enum logic [2:0] {
    MUL_NONE, MUL_FK, MUL_AB, MUL_SQ, MUL_RA
  } mul_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_INIT, ACT_WFACT, ACT_IDLE, ACT_RDM, ACT_LDR,
    ACT_CHK, ACT_SHIFT, ACT_WINV, ACT_NEXTH, ACT_OUT
  } act_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_K_END, C_NO_FIRE, C_E_ZERO, C_HIT, C_SEL, C_OUT_FULL
  } cond_t;

  localparam int unsigned PC_W = 5;

  typedef struct packed {
    logic            hold;
    mul_t            mul;
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // program step addresses
  localparam logic [PC_W-1:0] ST_INIT  = 5'd0;
  localparam logic [PC_W-1:0] ST_FLOOP = 5'd1;
  localparam logic [PC_W-1:0] ST_FMUL  = 5'd2;
  localparam logic [PC_W-1:0] ST_FWR   = 5'd3;
  localparam logic [PC_W-1:0] ST_IDLE  = 5'd4;
  localparam logic [PC_W-1:0] ST_RDM   = 5'd5;
  localparam logic [PC_W-1:0] ST_LDR   = 5'd6;
  localparam logic [PC_W-1:0] ST_CHK   = 5'd7;
  localparam logic [PC_W-1:0] ST_POW   = 5'd8;
  localparam logic [PC_W-1:0] ST_SQR   = 5'd9;
  localparam logic [PC_W-1:0] ST_PWAIT = 5'd10;
  localparam logic [PC_W-1:0] ST_WINV  = 5'd11;
  localparam logic [PC_W-1:0] ST_MULR  = 5'd12;
  localparam logic [PC_W-1:0] ST_RWAIT = 5'd13;
  localparam logic [PC_W-1:0] ST_NEXTH = 5'd14;
  localparam logic [PC_W-1:0] ST_RDH   = 5'd15;
  localparam logic [PC_W-1:0] ST_OWAIT = 5'd16;
  localparam logic [PC_W-1:0] ST_OUT   = 5'd17;

  // control store: one word per step, jump to target when cond holds
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{hold: 1'b0, mul: MUL_NONE, act: ACT_NONE, cond: C_NEVER, target: ST_INIT};
    unique case (pc)
      ST_INIT:  w.act = ACT_INIT;
      ST_FLOOP: begin w.cond = C_K_END; w.target = ST_IDLE; end
      ST_FMUL:  w.mul = MUL_FK;
      ST_FWR:   begin
        w.hold = 1'b1; w.act = ACT_WFACT; w.cond = C_ALWAYS; w.target = ST_FLOOP;
      end
      ST_IDLE:  begin w.act = ACT_IDLE; w.cond = C_NO_FIRE; w.target = ST_IDLE; end
      ST_RDM:   w.act = ACT_RDM;
      ST_LDR:   w.act = ACT_LDR;
      ST_CHK:   begin w.act = ACT_CHK; w.cond = C_HIT; w.target = ST_MULR; end
      ST_POW:   begin w.mul = MUL_AB; w.cond = C_E_ZERO; w.target = ST_WINV; end
      ST_SQR:   begin w.mul = MUL_SQ; w.act = ACT_SHIFT; end
      ST_PWAIT: begin w.hold = 1'b1; w.cond = C_ALWAYS; w.target = ST_POW; end
      ST_WINV:  w.act = ACT_WINV;
      ST_MULR:  w.mul = MUL_RA;
      ST_RWAIT: begin w.hold = 1'b1; w.cond = C_SEL; w.target = ST_OWAIT; end
      ST_NEXTH: w.act = ACT_NEXTH;
      ST_RDH:   begin w.cond = C_ALWAYS; w.target = ST_CHK; end
      ST_OWAIT: begin w.cond = C_OUT_FULL; w.target = ST_OWAIT; end
      ST_OUT:   begin w.act = ACT_OUT; w.cond = C_ALWAYS; w.target = ST_IDLE; end
      default:  begin w.cond = C_ALWAYS; w.target = ST_IDLE; end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/cbm_if.sv =====
// valid/ready channel interfaces for queries and answers
// depends on cbm_pkg
interface cbm_query_if;
  import cbm_pkg::*;
  logic           valid;
  logic           ready;
  logic [N_W-1:0] n;
  modport source (output valid, output n, input ready);
  modport sink   (input valid, input n, output ready);
endinterface

interface cbm_answer_if;
  import cbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/cbm_modmul.sv =====
// four-stage modular multiplier: product, barrett quotient, q*p, correction
// depends on cbm_pkg
module cbm_modmul (
  input  logic             clk,
  input  logic             rst,
  input  cbm_pkg::mm_req_t req,
  output cbm_pkg::mm_rsp_t rsp
);
  import cbm_pkg::*;

  localparam int unsigned HI_W    = PROD_W - (VAL_W - 1);
  localparam int unsigned QFULL_W = HI_W + MU_W;
  localparam int unsigned QP_W    = MU_W + VAL_W;

  logic v1, v2, v3, v4;
  dst_t d1, d2, d3, d4;
  logic [PROD_W-1:0]  prod1;
  logic [MU_W-1:0]    q2;
  logic [RED_W-1:0]   lo2, lo3, qp3;
  logic [VAL_W-1:0]   res4;
  logic [QFULL_W-1:0] qfull;
  logic [QP_W-1:0]    qpfull;
  logic [RED_W-1:0]   diff, p1, p2;
  logic [VAL_W-1:0]   fixed;

  // quotient estimate and residue correction
  always_comb begin
    qfull  = QFULL_W'(prod1[PROD_W-1:VAL_W-1]) * QFULL_W'(MU);
    qpfull = QP_W'(q2) * QP_W'(PRIME);
    p1     = RED_W'(PRIME);
    p2     = RED_W'(PRIME) << 1;
    diff   = lo3 - qp3;
    priority if (diff >= p2) fixed = VAL_W'(diff - p2);
    else if (diff >= p1)     fixed = VAL_W'(diff - p1);
    else                     fixed = VAL_W'(diff);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v1 <= req.valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    prod1 <= PROD_W'(req.a) * PROD_W'(req.b);
    d1    <= req.dest;
    q2    <= qfull[QFULL_W-1:VAL_W+1];
    lo2   <= prod1[RED_W-1:0];
    d2    <= d1;
    qp3   <= qpfull[RED_W-1:0];
    lo3   <= lo2;
    d3    <= d2;
    res4  <= fixed;
    d4    <= d3;
  end

  assign rsp.valid = v4;
  assign rsp.busy  = v1 | v2 | v3 | v4;
  assign rsp.dest  = d4;
  assign rsp.value = res4;

endmodule

// ===== rtl/central_binomial_mod_prime.sv =====
// central binomial coefficient mod 1000000007; depends on cbm_pkg, cbm_if, cbm_modmul
// a query whose inverses are both cached skips the exponentiation; each inverse that is
//   computed takes 30 exponent steps through the four-stage modular multiplier; the next
//   query is taken once the answer register loads
// reset: synchronous; after reset the factorial table fills and the inverse cache clears,
//   during which no query is taken
module central_binomial_mod_prime #(
  parameter int unsigned MAX_N = 4096
) (
  input  logic                clk,
  input  logic                rst,
  cbm_query_if.sink           query,
  cbm_answer_if.source        answer
);
  import cbm_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_N);
  localparam int unsigned K_W   = IDX_W + 1;
  localparam int unsigned CL_W  = (K_W > N_W) ? K_W : N_W;

  // sequencer
  logic [PC_W-1:0] pc, pc_next;
  ctrl_t           ctrl;
  logic            go, take, fire;

  // datapath registers
  logic [K_W-1:0]   k;
  logic [IDX_W-1:0] m, h;
  logic             sel;
  logic [VAL_W-1:0] f, r, acc, base, e;

  // memories
  logic [VAL_W-1:0] fact_mem [MAX_N];
  logic [VAL_W-1:0] inv_mem  [MAX_N];
  logic [VAL_W-1:0] fact_q, inv_q, fact_wd, inv_wd;
  logic [IDX_W-1:0] fact_wa, fact_ra, inv_wa;
  logic             fact_we, inv_we;

  // query clamp
  logic [CL_W-1:0]  n_ext, n_sat;
  logic [IDX_W-1:0] m_new;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  cbm_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  assign ctrl        = ucode(pc);
  assign go          = !(ctrl.hold && mm_rsp.busy);
  assign query.ready = (ctrl.act == ACT_IDLE);
  assign fire        = query.valid && query.ready;

  // clamp n into 1..MAX_N, then m = n-1
  always_comb begin
    n_ext = CL_W'(query.n);
    priority if (n_ext == '0)          n_sat = CL_W'(1);
    else if (n_ext > CL_W'(MAX_N))     n_sat = CL_W'(MAX_N);
    else                               n_sat = n_ext;
    m_new = IDX_W'(n_sat - CL_W'(1));
  end

  // jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_K_END:    take = (k == K_W'(MAX_N));
      C_NO_FIRE:  take = !fire;
      C_E_ZERO:   take = (e == '0);
      C_HIT:      take = (inv_q != '0);
      C_SEL:      take = sel;
      C_OUT_FULL: take = answer.valid && !answer.ready;
      default:    take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (!go) pc_next = pc;
    else if (take)    pc_next = ctrl.target;
    else              pc_next = pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= ST_INIT;
    else     pc <= pc_next;
  end

  // multiplier issue
  always_comb begin
    mm_req.valid = 1'b0;
    mm_req.dest  = DST_F;
    mm_req.a     = f;
    mm_req.b     = VAL_W'(k);
    unique case (ctrl.mul)
      MUL_NONE: mm_req.valid = 1'b0;
      MUL_FK:   begin
        mm_req.valid = go;
      end
      MUL_AB:   begin
        mm_req.valid = go && e[0];
        mm_req.dest  = DST_ACC;
        mm_req.a     = acc;
        mm_req.b     = base;
      end
      MUL_SQ:   begin
        mm_req.valid = go;
        mm_req.dest  = DST_BASE;
        mm_req.a     = base;
        mm_req.b     = base;
      end
      MUL_RA:   begin
        mm_req.valid = go;
        mm_req.dest  = DST_R;
        mm_req.a     = r;
        mm_req.b     = acc;
      end
      default:  mm_req.valid = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    fact_we = go && (ctrl.act == ACT_INIT || ctrl.act == ACT_WFACT);
    fact_wa = (ctrl.act == ACT_INIT) ? '0 : k[IDX_W-1:0];
    fact_wd = (ctrl.act == ACT_INIT) ? VAL_W'(1) : f;
    fact_ra = (ctrl.act == ACT_RDM) ? m : h;
    inv_we  = go && (ctrl.act == ACT_INIT || ctrl.act == ACT_WFACT ||
                     ctrl.act == ACT_WINV);
    inv_wa  = (ctrl.act == ACT_WINV) ? h :
              ((ctrl.act == ACT_INIT) ? '0 : k[IDX_W-1:0]);
    inv_wd  = (ctrl.act == ACT_WINV) ? acc : '0;
  end

  // factorial table
  always_ff @(posedge clk) begin
    if (fact_we) fact_mem[fact_wa] <= fact_wd;
    fact_q <= fact_mem[fact_ra];
  end

  // inverse cache, zero marks an entry not yet computed
  always_ff @(posedge clk) begin
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    inv_q <= inv_mem[h];
  end

  // datapath actions and multiplier writeback
  always_ff @(posedge clk) begin
    if (go) begin
      unique case (ctrl.act)
        ACT_INIT: begin
          f <= VAL_W'(1);
          k <= K_W'(1);
        end
        ACT_WFACT: k <= k + K_W'(1);
        ACT_IDLE: begin
          if (fire) begin
            m   <= m_new;
            h   <= m_new >> 1;
            sel <= 1'b0;
          end
        end
        ACT_LDR: r <= fact_q;
        ACT_CHK: begin
          base <= fact_q;
          e    <= FERMAT_EXP;
          acc  <= (inv_q != '0) ? inv_q : VAL_W'(1);
        end
        ACT_SHIFT: e <= e >> 1;
        ACT_NEXTH: begin
          sel <= 1'b1;
          h   <= IDX_W'((K_W'(m) + K_W'(1)) >> 1);
        end
        ACT_OUT: answer.value <= r;
        default: ;
      endcase
    end
    if (mm_rsp.valid) begin
      unique case (mm_rsp.dest)
        DST_F:    f    <= mm_rsp.value;
        DST_ACC:  acc  <= mm_rsp.value;
        DST_BASE: base <= mm_rsp.value;
        DST_R:    r    <= mm_rsp.value;
        default:  ;
      endcase
    end
  end

  // answer register valid
  always_ff @(posedge clk) begin
    if (rst)                                 answer.valid <= 1'b0;
    else if (go && ctrl.act == ACT_OUT)      answer.valid <= 1'b1;
    else if (answer.ready)                   answer.valid <= 1'b0;
  end

endmodule

// ===== rtl/cbm_checker.sv =====
// port-level checks for the central binomial block, bound to the top level
// depends on cbm_pkg and central_binomial_mod_prime_assert.svh
`include "central_binomial_mod_prime_assert.svh"

module cbm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      query_valid,
  input logic                      query_ready,
  input logic                      answer_valid,
  input logic                      answer_ready,
  input logic [cbm_pkg::VAL_W-1:0] answer_value
);
  import cbm_pkg::*;

  // nothing taken or offered right after reset
  `CBM_ASSERT_RESET(a_reset_quiet, !query_ready && !answer_valid)
  // answers are reduced residues
  `CBM_ASSERT_NOW(a_value_range, answer_valid, answer_value < PRIME)
  // one query in work at a time
  `CBM_ASSERT_NEXT(a_one_at_a_time, query_valid && query_ready, !query_ready)
  // a stalled answer holds
  `CBM_ASSERT_NEXT(a_answer_held, answer_valid && !answer_ready, answer_valid && $stable(answer_value))

endmodule

bind central_binomial_mod_prime cbm_checker u_cbm_checker (
  .clk          (clk),
  .rst          (rst),
  .query_valid  (query.valid),
  .query_ready  (query.ready),
  .answer_valid (answer.valid),
  .answer_ready (answer.ready),
  .answer_value (answer.value)
);

// ===== test/tb_top.sv =====
// self-checking testbench for central_binomial_mod_prime: random and corner counts,
// answers compared against an internal factorial / fermat-inverse predictor
// depends on cbm_pkg, cbm_if and the block under test
module tb_top;
  import cbm_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 4096;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned DRAIN_CYCLES   = 500;

  logic clk;
  logic rst;

  cbm_query_if  query_if ();
  cbm_answer_if answer_if ();

  central_binomial_mod_prime #(
    .MAX_N (TABLE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .query  (query_if),
    .answer (answer_if)
  );

  // predictor state: k! mod p and memoized inverses, zero means not computed
  logic [VAL_W-1:0] fact_mod      [TABLE_DEPTH];
  logic [VAL_W-1:0] inv_fact_memo [TABLE_DEPTH];

  logic [VAL_W-1:0] expected_values [$];
  int unsigned      error_count;
  int unsigned      stall_cycles;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;

  // clock
  always #2 clk = ~clk;

  function automatic logic [VAL_W-1:0] mul_mod_p(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
    logic [63:0] prod;
    logic [63:0] rem;
    prod = {34'd0, a} * {34'd0, b};
    rem  = prod % {34'd0, PRIME};
    return rem[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] pow_mod_p(input logic [VAL_W-1:0] base,
                                                 input logic [VAL_W-1:0] expo);
    logic [VAL_W-1:0] acc;
    logic [VAL_W-1:0] sq;
    logic [VAL_W-1:0] rest;
    acc  = 1;
    sq   = base;
    rest = expo;
    while (rest != '0) begin
      if (rest[0]) acc = mul_mod_p(acc, sq);
      sq   = mul_mod_p(sq, sq);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic logic [VAL_W-1:0] inv_fact(input int unsigned k);
    if (inv_fact_memo[k] == '0) inv_fact_memo[k] = pow_mod_p(fact_mod[k], FERMAT_EXP);
    return inv_fact_memo[k];
  endfunction

  // C(m, floor(m/2)) mod p with m = clamp(n) - 1
  function automatic logic [VAL_W-1:0] central_binom(input logic [N_W-1:0] n_raw);
    int unsigned      cnt;
    int unsigned      m;
    logic [VAL_W-1:0] r;
    cnt = n_raw;
    if (cnt == 0) cnt = 1;
    if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
    m = cnt - 1;
    r = mul_mod_p(fact_mod[m], inv_fact(m >> 1));
    r = mul_mod_p(r, inv_fact((m + 1) >> 1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // one query transfer; called and returns at a falling edge, valid left high
  task automatic send_query(input logic [N_W-1:0] nv);
    while ($urandom_range(99) < tx_idle_pct) begin
      query_if.valid <= 1'b0;
      @(negedge clk);
    end
    query_if.valid <= 1'b1;
    query_if.n     <= nv;
    @(posedge clk);
    while (!query_if.ready) @(posedge clk);
    expected_values.push_back(central_binom(nv));
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    answer_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // answer checker
  always @(posedge clk) begin : check_answers
    logic [VAL_W-1:0] want;
    if (!rst && answer_if.valid && answer_if.ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("answer with no query pending", answer_if.value, '0);
      end else begin
        want = expected_values.pop_front();
        if (answer_if.value != want) report_mismatch("value", answer_if.value, want);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((query_if.valid && query_if.ready) || (answer_if.valid && answer_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // corner counts: zero, one, top of table, saturation, bit patterns, repeats
  task automatic test_corner_counts();
    logic [N_W-1:0] corner_list [$];
    corner_list = '{13'd1, 13'd0, 13'd2, 13'd3, 13'd4, 13'd5, 13'd4096, 13'd4095,
                    13'd4097, 13'd8191, 13'd8190, 13'd6000, 13'd4096, 13'd1, 13'd0,
                    13'd2048, 13'd2049, 13'd1024, 13'h0AAA, 13'h1555, 13'd100, 13'd101};
    foreach (corner_list[i]) send_query(corner_list[i]);
  endtask

  // random counts, mostly in range, some small to revisit cached inverses
  task automatic test_random_queries(input int count);
    int             pick;
    logic [N_W-1:0] nv;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55)      nv = N_W'($urandom_range(4096, 1));
      else if (pick < 80) nv = N_W'($urandom_range(48, 1));
      else if (pick < 90) nv = N_W'($urandom_range(8191, 4097));
      else if (pick < 93) nv = '0;
      else                nv = N_W'($urandom_range(4096, 4000));
      send_query(nv);
    end
  endtask

  // hold off new queries until every answer is back, then resume
  task automatic test_drain_then_resume();
    query_if.valid <= 1'b0;
    @(negedge clk);
    while (expected_values.size() != 0) @(negedge clk);
    send_query(13'd4096);
    send_query(13'd7);
    send_query(13'd0);
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    query_if.valid  = 1'b0;
    query_if.n      = '0;
    answer_if.ready = 1'b0;
    error_count     = 0;
    stall_cycles    = 0;
    tx_idle_pct     = 17;
    rx_idle_pct     = 65;

    // predictor tables
    fact_mod[0]      = 1;
    inv_fact_memo[0] = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      fact_mod[k]      = mul_mod_p(fact_mod[k-1], VAL_W'(k));
      inv_fact_memo[k] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corner_counts();
    test_random_queries(300);
    test_drain_then_resume();

    tx_idle_pct = 65;
    rx_idle_pct = 17;
    test_random_queries(310);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_queries(310);

    // drain and let any stray answer show up
    query_if.valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
